[src/ordered_rule_tokenizer_unit_macros.svh]
// Assertion macros used by the checker file.
`ifndef ORDERED_RULE_TOKENIZER_UNIT_MACROS_SVH
`define ORDERED_RULE_TOKENIZER_UNIT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ORT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ORT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/ort_pkg.sv]
`timescale 1ns / 1ps

package ort_pkg;

  typedef enum logic [3:0] {
    MODE_START   = 4'b0001,
    MODE_INT     = 4'b0010,
    MODE_IDENT   = 4'b0100,
    MODE_COMMENT = 4'b1000
  } scan_mode_e;

  typedef enum logic [3:0] {
    KIND_FUNC    = 4'd0,
    KIND_EXTERN  = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_MINUS   = 4'd3,
    KIND_TIMES   = 4'd4,
    KIND_DIVIDE  = 4'd5,
    KIND_COMMA   = 4'd6,
    KIND_LPAREN  = 4'd7,
    KIND_RPAREN  = 4'd8,
    KIND_INTEGER = 4'd9,
    KIND_IDENT   = 4'd10
  } token_kind_e;

  // bit 0: may still be "func", bit 1: may still be "extern"
  typedef enum logic [1:0] {
    KW_NONE   = 2'b00,
    KW_FUNC   = 2'b01,
    KW_EXTERN = 2'b10
  } kw_flags_e;

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = OUT_PTR_W + 1;

  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_HASH = "#";

  localparam logic [2:0] FUNC_LEN   = 3'd4;
  localparam logic [2:0] EXTERN_LEN = 3'd6;

  typedef struct packed {
    logic        valid;
    token_kind_e kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
  } token_t;

  typedef struct packed {
    logic        last;
    token_kind_e kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
  } result_t;

  typedef struct packed {
    logic        hit;
    token_kind_e kind;
  } op_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic logic [7:0] kw_char(input logic is_func, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (is_func) begin
      case (idx)
        3'd0: ch = "f";
        3'd1: ch = "u";
        3'd2: ch = "n";
        3'd3: ch = "c";
        default: ch = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0: ch = "e";
        3'd1: ch = "x";
        3'd2: ch = "t";
        3'd3: ch = "e";
        3'd4: ch = "r";
        3'd5: ch = "n";
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic op_t op_lookup(input logic [7:0] c);
    op_t op;
    op.hit  = 1'b1;
    op.kind = KIND_PLUS;
    case (c)
      "+": op.kind = KIND_PLUS;
      "-": op.kind = KIND_MINUS;
      "*": op.kind = KIND_TIMES;
      "/": op.kind = KIND_DIVIDE;
      ",": op.kind = KIND_COMMA;
      "(": op.kind = KIND_LPAREN;
      ")": op.kind = KIND_RPAREN;
      default: op.hit = 1'b0;
    endcase
    return op;
  endfunction

endpackage

[src/ordered_rule_tokenizer_unit.sv]
// Each byte taken is registered in the input stage; its tokens are written into
// the result queue. Throughput: one byte per cycle unless the queue stalls input;
// the scan state updates once per byte. A byte gives up to two tokens (only two
// are kept at end of text), queued in a 4-entry result queue, sent one per cycle
// while the output is ready; input stalls only when fewer than two slots are free.
// Reset clears the queue, input stage and scan state; first_line returns to 1.
`timescale 1ns / 1ps

module ordered_rule_tokenizer_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // text_byte
  input  logic                 s_axis_tlast,   // end_of_text
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // line_number, column, token_length
  output ort_pkg::token_kind_e m_axis_tuser,   // token_kind
  output logic                 m_axis_tlast,   // last_of_run
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i     // first_line
);
  import ort_pkg::*;

  localparam logic [COUNT_BITS+15:0] WIDE_16_MAX  = {{COUNT_BITS{1'b0}}, 16'hFFFF};
  localparam logic [COUNT_BITS+15:0] WIDE_CNT_MAX = {16'd0, {COUNT_BITS{1'b1}}};

  typedef struct packed {
    scan_mode_e            mode;
    kw_flags_e             kw;
    logic [COUNT_BITS-1:0] plen;
    logic [COUNT_BITS-1:0] pcol;
    logic [COUNT_BITS-1:0] ccol;
    logic [COUNT_BITS-1:0] line;
  } scan_t;

  typedef struct packed {
    scan_t  s;
    token_t a;
    token_t b;
  } step_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [15:0] out16(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+15:0] w;
    w = {16'd0, v};
    return (w > WIDE_16_MAX) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] clamp_line(input logic [15:0] v);
    logic [COUNT_BITS+15:0] w;
    w = {{COUNT_BITS{1'b0}}, v};
    return (w > WIDE_CNT_MAX) ? {COUNT_BITS{1'b1}} : w[COUNT_BITS-1:0];
  endfunction

  function automatic token_t mk_tok(input token_kind_e k,
                                    input logic [COUNT_BITS-1:0] ln,
                                    input logic [COUNT_BITS-1:0] col,
                                    input logic [COUNT_BITS-1:0] len);
    token_t t;
    t.valid = 1'b1;
    t.kind  = k;
    t.line  = out16(ln);
    t.col   = out16(col);
    t.len   = out16(len);
    return t;
  endfunction

  function automatic step_t take_byte(input scan_t si, input logic [7:0] c);
    step_t      r;
    logic       start;
    logic       word;
    logic       kw_hit;
    logic [2:0] klen;
    op_t        op;
    r       = '0;
    r.s     = si;
    start   = 1'b0;
    word    = is_word(c) || is_digit(c);
    klen    = si.kw[0] ? FUNC_LEN : EXTERN_LEN;
    kw_hit  = (si.kw != KW_NONE) && (si.plen < COUNT_BITS'(klen)) &&
              (c == kw_char(si.kw[0], si.plen[2:0]));
    op      = op_lookup(c);
    case (si.mode)
      MODE_COMMENT: begin
        if (c == CHAR_NL) begin
          r.s.line = sat_inc(si.line);
          r.s.ccol = '0;
          r.s.mode = MODE_START;
        end else begin
          r.s.ccol = sat_inc(si.ccol);
        end
      end
      MODE_IDENT: begin
        if (word) begin
          r.s.ccol = sat_inc(si.ccol);
          r.s.plen = sat_inc(si.plen);
          if (kw_hit) begin
            if (si.plen == COUNT_BITS'(klen - 3'd1)) begin
              r.a = mk_tok(si.kw[0] ? KIND_FUNC : KIND_EXTERN, si.line, si.pcol,
                           COUNT_BITS'(klen));
              r.s.mode = MODE_START;
              r.s.kw   = KW_NONE;
              r.s.plen = '0;
            end
          end else begin
            r.s.kw = KW_NONE;
          end
        end else begin
          r.a      = mk_tok(KIND_IDENT, si.line, si.pcol, si.plen);
          r.s.mode = MODE_START;
          r.s.kw   = KW_NONE;
          r.s.plen = '0;
          start    = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit(c) || c == "_") begin
          r.s.plen = sat_inc(si.plen);
          r.s.ccol = sat_inc(si.ccol);
        end else begin
          r.a      = mk_tok(KIND_INTEGER, si.line, si.pcol, si.plen);
          r.s.mode = MODE_START;
          r.s.plen = '0;
          start    = 1'b1;
        end
      end
      default: start = 1'b1;
    endcase
    if (start) begin
      if (c == CHAR_NL) begin
        r.s.line = sat_inc(si.line);
        r.s.ccol = '0;
      end else begin
        if (c == CHAR_HASH) begin
          r.s.mode = MODE_COMMENT;
        end else if (is_digit(c)) begin
          r.s.mode = MODE_INT;
          r.s.pcol = si.ccol;
          r.s.plen = COUNT_BITS'(1);
        end else if (is_word(c)) begin
          r.s.mode = MODE_IDENT;
          r.s.pcol = si.ccol;
          r.s.plen = COUNT_BITS'(1);
          r.s.kw   = (c == "f") ? KW_FUNC : ((c == "e") ? KW_EXTERN : KW_NONE);
        end else if (op.hit) begin
          r.b = mk_tok(op.kind, si.line, si.ccol, COUNT_BITS'(1));
        end
        r.s.ccol = sat_inc(si.ccol);
      end
    end
    return r;
  endfunction

  // input stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;

  // scan state
  scan_t       scan_q, scan_d;
  logic        started_q, started_d;
  logic [15:0] first_line_q, first_line_d;

  // result queue
  result_t              fifo_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0] count_q, count_d;

  logic    adv;
  logic    pop;
  step_t   step1, step2;
  scan_t   restart;
  token_t  toks [4];
  logic [2:0] n_tok;
  logic [1:0] push_n;
  result_t res0, res1;
  result_t head;

  assign adv           = in_vld_q && (count_q <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign s_axis_tready = !in_vld_q || adv;

  assign step1 = take_byte(scan_q, in_byte_q);
  assign step2 = take_byte(step1.s, CHAR_NL);

  always_comb begin
    restart      = '0;
    restart.mode = MODE_START;
    restart.kw   = KW_NONE;
    restart.line = clamp_line(first_line_q);
  end

  always_comb begin
    toks[0] = step1.a;
    toks[1] = step1.b;
    toks[2] = step2.a;
    toks[3] = step2.b;
    if (!in_eot_q) begin
      toks[2].valid = 1'b0;
      toks[3].valid = 1'b0;
    end
    res0  = '0;
    res1  = '0;
    n_tok = '0;
    for (int i = 0; i < 4; i++) begin
      if (toks[i].valid) begin
        if (n_tok == 3'd0) begin
          res0 = '{last: 1'b0, kind: toks[i].kind, line: toks[i].line,
                   col: toks[i].col, len: toks[i].len};
        end else if (n_tok == 3'd1) begin
          res1 = '{last: 1'b1, kind: toks[i].kind, line: toks[i].line,
                   col: toks[i].col, len: toks[i].len};
        end
        n_tok = n_tok + 3'd1;
      end
    end
    res0.last = (n_tok == 3'd1);
    if (!adv) begin
      push_n = 2'd0;
    end else if (n_tok >= 3'd2) begin
      push_n = 2'd2;
    end else begin
      push_n = n_tok[1:0];
    end
  end

  always_comb begin
    scan_d       = scan_q;
    started_d    = started_q;
    first_line_d = first_line_q;
    if (adv) begin
      started_d = !in_eot_q;
      scan_d    = in_eot_q ? restart : step1.s;
    end
    if (cfg_we_i) begin
      first_line_d = cfg_wdata_i;
      if (!started_q && !adv) begin
        scan_d.line = clamp_line(cfg_wdata_i);
      end
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {head.len, head.col, head.line};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign pop           = m_axis_tvalid && m_axis_tready;

  assign wr_ptr_nxt = wr_ptr_q + OUT_PTR_W'(1);
  assign wr_ptr_d   = wr_ptr_q + OUT_PTR_W'(push_n);
  assign rd_ptr_d   = rd_ptr_q + OUT_PTR_W'(pop);
  assign count_d    = count_q + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      scan_q       <= '{mode: MODE_START, kw: KW_NONE, plen: '0, pcol: '0, ccol: '0,
                        line: COUNT_BITS'(1)};
      started_q    <= 1'b0;
      first_line_q <= 16'd1;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      scan_q       <= scan_d;
      started_q    <= started_d;
      first_line_q <= first_line_d;
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_nxt] <= res1;
    end
  end

endmodule

[src/ort_checker.sv]
`timescale 1ns / 1ps
`include "ordered_rule_tokenizer_unit_macros.svh"

module ort_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [47:0]          m_axis_tdata,
  input ort_pkg::token_kind_e m_axis_tuser
);
  import ort_pkg::*;

  `ORT_ASSERT_ALWAYS(a_no_item_in_reset, !rst_ni |-> !m_axis_tvalid, "item shown during reset")
  `ORT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled item changed")
  `ORT_ASSERT(a_len_nonzero, m_axis_tvalid |-> (m_axis_tdata[47:32] != 16'd0), "zero token length")
  `ORT_ASSERT(a_func_len, m_axis_tvalid && (m_axis_tuser == KIND_FUNC) |-> (m_axis_tdata[47:32] == 16'd4), "func length wrong")
  `ORT_ASSERT(a_extern_len, m_axis_tvalid && (m_axis_tuser == KIND_EXTERN) |-> (m_axis_tdata[47:32] == 16'd6), "extern length wrong")

endmodule

bind ordered_rule_tokenizer_unit ort_checker u_ort_checker (.*);
